/* hdl/interrupt_and_tape_status_ports_assert.svh */
// assertion macros for the interrupt and tape status ports block
// depends on nothing; included by the top level only
`ifndef INTERRUPT_AND_TAPE_STATUS_PORTS_ASSERT_SVH
`define INTERRUPT_AND_TAPE_STATUS_PORTS_ASSERT_SVH
`ifndef SYNTHESIS
`define ITSP_ASSERT_IMPLY(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("itsp check failed");
`define ITSP_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("itsp check failed");
`else
`define ITSP_ASSERT_IMPLY(label, clk, rst, cond, prop)
`define ITSP_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

/* hdl/itsp_pkg.sv */
// types and constants for the interrupt and tape status ports block
// no dependencies; imported by the top level
`default_nettype none

package itsp_pkg;

  // tape sample width, Q1.(SAMPLE_BITS-1)
  localparam int SAMPLE_BITS = 16;

  localparam logic signed [15:0] THRESHOLD_RESET = -16'sd6554;
  localparam logic [10:0] MOTOR_TIMEOUT_RESET = 11'd1600;

  typedef enum logic [2:0] {
    KIND_READ   = 3'd0,
    KIND_WRITE  = 3'd1,
    KIND_SAMPLE = 3'd2,
    KIND_TICK   = 3'd3,
    KIND_INTRQ  = 3'd4,
    KIND_DRQ    = 3'd5
  } kind_t;

  typedef enum logic {
    CFG_THRESHOLD = 1'b0,
    CFG_MOTOR     = 1'b1
  } cfg_index_t;

  // port groups, address bits 7:2
  localparam logic [5:0] PORT_INT   = 6'h38;  // e0-e3
  localparam logic [5:0] PORT_NMI   = 6'h39;  // e4-e7
  localparam logic [5:0] PORT_CLOCK = 6'h3b;  // ec-ef
  localparam logic [5:0] PORT_DRIVE = 6'h3d;  // f4-f7
  localparam logic [5:0] PORT_TAPE  = 6'h3f;  // fc-ff

  // flag bits
  localparam logic [7:0] FL_RISE   = 8'h01;
  localparam logic [7:0] FL_FALL   = 8'h02;
  localparam logic [7:0] FL_CLOCK  = 8'h04;
  localparam logic [7:0] NMI_INTRQ = 8'h80;
  localparam logic [7:0] TAPE_SLOW = 8'h80;
  localparam logic [7:0] HW_MASK   = 8'h7e;
  localparam logic [7:0] TAPE_CLEAR_MASK = 8'hfc;
  localparam logic [7:0] SEL_WAIT  = 8'h40;
  localparam logic [7:0] SEL_DRIVES = 8'h03;
  localparam logic [7:0] UNMAPPED_DATA = 8'hff;

  typedef struct packed {
    logic [2:0]                    kind;
    logic [7:0]                    port;
    logic [7:0]                    write_data;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          line_level;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       int_request;
    logic       nmi_request;
    logic       wait_request;
    logic       motor_on;
  } result_t;

endpackage

`default_nettype wire

/* hdl/interrupt_and_tape_status_ports.sv */
// top level of the interrupt, nmi, tape-edge and disk-motor status logic
// depends on itsp_pkg and interrupt_and_tape_status_ports_assert.svh
//
//   channel   handshake                 payload
//   item      item_valid / item_stall   item (itsp_pkg::item_t)
//   result    result_valid / result_stall  result (itsp_pkg::result_t)
//   cfg       cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one item per cycle while the result is not stalled; each item passes through the
// input register and then its result sits in the output register.
// state updates happen as an item leaves the input register for the output.
// rst is synchronous and clears all flags and lines; the motor count resets to one.
// a stalled result holds the output register; the input register keeps taking
// items until it is full behind it. cfg_ready is always high.
`default_nettype none

`include "interrupt_and_tape_status_ports_assert.svh"

module interrupt_and_tape_status_ports
  import itsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output      logic        item_stall,
  input  wire item_t       item,
  output      logic        result_valid,
  input  wire logic        result_stall,
  output      result_t     result,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  // configuration registers
  logic signed [15:0] sample_threshold;
  logic [10:0]        motor_timeout_ticks;

  // block state
  logic [7:0]  pending_flags, pending_flags_next;
  logic [7:0]  int_enable, int_enable_next;
  logic [7:0]  nmi_enable, nmi_enable_next;
  logic [7:0]  nmi_flags, nmi_flags_next;
  logic [7:0]  tape_bits, tape_bits_next;
  logic [7:0]  hw_settings, hw_settings_next;
  logic signed [SAMPLE_BITS-1:0] prev_sample, prev_sample_next;
  logic [10:0] motor_count, motor_count_next;
  logic drive_selected, drive_selected_next;
  logic drq_idle, drq_idle_next;
  logic intrq_idle, intrq_idle_next;
  logic int_line, int_line_next;
  logic nmi_line, nmi_line_next;
  logic wait_line, wait_line_next;
  logic motor_line, motor_line_next;
  logic [7:0] read_data_next;

  // input register
  logic  stage_valid;
  item_t stage;

  logic out_hold;
  logic advance;
  logic signed [SAMPLE_BITS-1:0] threshold_scaled;
  logic fall_cross, rise_cross;

  assign cfg_ready  = 1'b1;
  assign out_hold   = result_valid && result_stall;
  assign item_stall = stage_valid && out_hold;
  assign advance    = stage_valid && !out_hold;

  // threshold rescaled to the sample width
  if (SAMPLE_BITS >= 16) begin : g_widen
    assign threshold_scaled = SAMPLE_BITS'(sample_threshold) <<< (SAMPLE_BITS - 16);
  end else begin : g_narrow
    assign threshold_scaled = SAMPLE_BITS'(sample_threshold >>> (16 - SAMPLE_BITS));
  end

  assign fall_cross = (prev_sample > threshold_scaled) && (stage.sample < threshold_scaled);
  assign rise_cross = (prev_sample < threshold_scaled) && (stage.sample > threshold_scaled);

  // next state and read data for the item in the input register
  always_comb begin
    pending_flags_next  = pending_flags;
    int_enable_next     = int_enable;
    nmi_enable_next     = nmi_enable;
    nmi_flags_next      = nmi_flags;
    tape_bits_next      = tape_bits;
    hw_settings_next    = hw_settings;
    prev_sample_next    = prev_sample;
    motor_count_next    = motor_count;
    drive_selected_next = drive_selected;
    drq_idle_next       = drq_idle;
    intrq_idle_next     = intrq_idle;
    int_line_next       = int_line;
    nmi_line_next       = nmi_line;
    wait_line_next      = wait_line;
    motor_line_next     = motor_line;
    read_data_next      = '0;
    unique case (stage.kind)
      KIND_READ: begin
        unique case (stage.port[7:2])
          PORT_INT: begin
            int_line_next  = 1'b0;
            read_data_next = ~(int_enable & pending_flags);
          end
          PORT_NMI: begin
            nmi_line_next  = 1'b0;
            nmi_flags_next = '0;
            read_data_next = ~(nmi_enable & nmi_flags);
          end
          PORT_CLOCK: begin
            pending_flags_next = pending_flags & ~FL_CLOCK;
          end
          PORT_TAPE: begin
            pending_flags_next = pending_flags & TAPE_CLEAR_MASK;
            read_data_next     = hw_settings | tape_bits;
          end
          default: read_data_next = UNMAPPED_DATA;
        endcase
      end
      KIND_WRITE: begin
        unique case (stage.port[7:2])
          PORT_INT: int_enable_next = stage.write_data;
          PORT_NMI: begin
            nmi_line_next   = 1'b0;
            nmi_enable_next = stage.write_data;
          end
          PORT_CLOCK: hw_settings_next = stage.write_data & HW_MASK;
          PORT_DRIVE: begin
            if ((stage.write_data & SEL_WAIT) != '0) begin
              if (drq_idle && intrq_idle) wait_line_next = 1'b1;
            end else begin
              wait_line_next = 1'b0;
            end
            drive_selected_next = (stage.write_data & SEL_DRIVES) != '0;
            if ((stage.write_data & SEL_DRIVES) != '0) begin
              motor_line_next  = 1'b1;
              motor_count_next = motor_timeout_ticks;
            end else begin
              motor_line_next = 1'b0;
            end
          end
          PORT_TAPE: tape_bits_next = tape_bits & ~TAPE_SLOW;
          default: ;
        endcase
      end
      KIND_SAMPLE: begin
        // falling crossing wins over rising
        priority if (fall_cross) begin
          tape_bits_next = tape_bits | TAPE_SLOW;
          if ((int_enable & FL_FALL) != '0) begin
            tape_bits_next     = '0;
            pending_flags_next = pending_flags | FL_FALL;
            int_line_next      = 1'b1;
          end
        end else if (rise_cross) begin
          if ((int_enable & FL_RISE) != '0) begin
            tape_bits_next     = 8'h01;
            pending_flags_next = pending_flags | FL_RISE;
            int_line_next      = 1'b1;
          end
        end else begin
          tape_bits_next = tape_bits;
        end
        prev_sample_next = stage.sample;
      end
      KIND_TICK: begin
        if ((int_enable & FL_CLOCK) != '0) begin
          pending_flags_next = pending_flags | FL_CLOCK;
          int_line_next      = 1'b1;
        end
        // motor timeout countdown
        if (motor_count != '0) begin
          motor_count_next = motor_count - 11'd1;
          if (motor_count == 11'd1 && drive_selected) motor_line_next = 1'b0;
        end
      end
      KIND_INTRQ: begin
        intrq_idle_next = !stage.line_level;
        if (stage.line_level) begin
          wait_line_next = 1'b0;
          if ((nmi_enable & NMI_INTRQ) != '0) begin
            nmi_flags_next = nmi_flags | NMI_INTRQ;
            nmi_line_next  = 1'b1;
          end
        end
      end
      KIND_DRQ: begin
        drq_idle_next = !stage.line_level;
        if (stage.line_level) wait_line_next = 1'b0;
      end
      default: ;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_threshold    <= THRESHOLD_RESET;
      motor_timeout_ticks <= MOTOR_TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_THRESHOLD: sample_threshold    <= cfg_data;
        CFG_MOTOR:     motor_timeout_ticks <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!item_stall) begin
      stage_valid <= item_valid;
    end
    if (!item_stall) stage <= item;
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid   <= 1'b0;
      pending_flags  <= '0;
      int_enable     <= '0;
      nmi_enable     <= '0;
      nmi_flags      <= '0;
      tape_bits      <= '0;
      hw_settings    <= '0;
      prev_sample    <= '0;
      motor_count    <= 11'd1;
      drive_selected <= 1'b0;
      drq_idle       <= 1'b1;
      intrq_idle     <= 1'b1;
      int_line       <= 1'b0;
      nmi_line       <= 1'b0;
      wait_line      <= 1'b0;
      motor_line     <= 1'b0;
    end else begin
      if (!out_hold) result_valid <= stage_valid;
      if (advance) begin
        pending_flags  <= pending_flags_next;
        int_enable     <= int_enable_next;
        nmi_enable     <= nmi_enable_next;
        nmi_flags      <= nmi_flags_next;
        tape_bits      <= tape_bits_next;
        hw_settings    <= hw_settings_next;
        prev_sample    <= prev_sample_next;
        motor_count    <= motor_count_next;
        drive_selected <= drive_selected_next;
        drq_idle       <= drq_idle_next;
        intrq_idle     <= intrq_idle_next;
        int_line       <= int_line_next;
        nmi_line       <= nmi_line_next;
        wait_line      <= wait_line_next;
        motor_line     <= motor_line_next;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      result.read_data    <= read_data_next;
      result.int_request  <= int_line_next;
      result.nmi_request  <= nmi_line_next;
      result.wait_request <= wait_line_next;
      result.motor_on     <= motor_line_next;
    end
  end

  // checks
  `ITSP_ASSERT_IMPLY(a_stall_only_when_full, clk, rst, item_stall, stage_valid && result_valid)
  `ITSP_ASSERT_IMPLY(a_motor_needs_drive, clk, rst, !drive_selected, !motor_line)
  `ITSP_ASSERT_IMPLY(a_nmi_has_flag, clk, rst, nmi_line, nmi_flags[7])
  `ITSP_ASSERT_NEXT(a_result_follows_stage, clk, rst, advance, result_valid)

endmodule

`default_nettype wire
